FILE: hdl/ddo_pkg.sv
package ddo_pkg;

    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [16:0] POLY_C0 = 17'd4639;
    localparam logic [16:0] POLY_C1 = 17'd42047;
    localparam logic [16:0] POLY_C2 = 17'd102944;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [15:0] IWB_RESET = 16'd256;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANG,
        S_DT,
        S_DELTA,
        S_HEAD,
        S_K,
        S_EST,
        S_CORR,
        S_ADJ,
        S_T,
        S_U,
        S_S,
        S_TRIG,
        S_POS,
        S_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [15:0] left_wheel_speed;
        logic signed [15:0] right_wheel_speed;
        logic [15:0]        time_step;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic [15:0]        heading_angle;
        logic signed [15:0] linear_velocity;
        logic signed [31:0] angular_velocity;
    } t_odo_out;

endpackage

FILE: hdl/ddo_mul.sv
module ddo_mul (
    input  logic                                 i_clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]    o_p
);
    import ddo_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: hdl/diff_drive_odometry_unit.sv
// After an input transfer the sequencer loads the result register in S_DONE.
// All 21 products of an update go through one registered 33x33 multiplier
// under the sequencer.
// The block takes no input while an item is in work.
// Reset (synchronous, active low) clears pose, heading, the output valid
// and sets the reciprocal wheel base to 1.0 per meter.
module diff_drive_odometry_unit #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ddo_pkg::t_odo_in  i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output ddo_pkg::t_odo_out o_out,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);
    import ddo_pkg::*;

    localparam int KW = $clog2(SINE_TABLE_DEPTH);
    localparam int XW = KW + 16;
    localparam logic signed [MUL_W-1:0] DEPTH_OP = MUL_W'(SINE_TABLE_DEPTH);
    localparam logic signed [MUL_W-1:0] RECIP_OP =
        MUL_W'((64'd1 << 39) / SINE_TABLE_DEPTH);
    localparam logic [XW-1:0] DEPTH_X = XW'(SINE_TABLE_DEPTH);

    t_state r_state, n_state;

    logic [15:0]        r_iwb;
    logic signed [15:0] r_left, r_right;
    logic [15:0]        r_dt;
    logic signed [15:0] r_lin;
    logic signed [31:0] r_ang;
    logic [15:0]        r_head;
    logic signed [31:0] r_x, r_y;
    logic               r_sin_pass;
    logic [KW-1:0]      r_k;
    logic [15:0]        r_est;
    logic [1:0]         r_quad;
    logic [16:0]        r_z;
    logic [16:0]        r_z2;
    t_odo_out           r_out;
    logic               r_out_valid;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [16:0] diff;
    logic signed [16:0] lin_sum;
    logic signed [31:0] ang_sat;
    logic signed [31:0] q_rad;
    logic [15:0]        delta;
    logic [15:0]        head_sel;
    logic [KW-1:0]      k_idx;
    logic [15:0]        est;
    logic [XW-1:0]      rem;
    logic [15:0]        ang_a;
    logic [14:0]        z_mirror;
    logic [16:0]        z_val;
    logic [16:0]        hi17;
    logic [15:0]        mag;
    logic signed [16:0] trig;
    logic signed [26:0] dpos;
    logic signed [31:0] acc_sel;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic               out_xfer;

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    always_comb begin
        diff     = {r_right[15], r_right} - {r_left[15], r_left};
        lin_sum  = {r_left[15], r_left} + {r_right[15], r_right};
        if (prod[PROD_W-1:31] == '0 || prod[PROD_W-1:31] == '1) begin
            ang_sat = prod[31:0];
        end else if (prod[PROD_W-1]) begin
            ang_sat = 32'sh8000_0000;
        end else begin
            ang_sat = 32'sh7fff_ffff;
        end
        q_rad    = prod[47:16];
        delta    = prod[47:32];
        head_sel = r_sin_pass ? r_head : 16'(r_head + QUARTER_TURN);
        k_idx    = prod[16+KW-1:16];
        est      = prod[54:39];
        rem      = {r_k, 16'h0} - prod[XW-1:0];
        ang_a    = (rem >= DEPTH_X) ? 16'(r_est + 16'd1) : r_est;
        z_mirror = 15'(15'd16384 - {1'b0, ang_a[13:0]});
        z_val    = ang_a[14] ? {z_mirror, 2'b00} : {1'b0, ang_a[13:0], 2'b00};
        hi17     = prod[32:16];
        mag      = prod[33:18];
        trig     = r_quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        dpos     = prod[48:22];
        acc_sel  = r_sin_pass ? r_y : r_x;
        acc_sum  = {acc_sel[31], acc_sel} + {{6{dpos[26]}}, dpos};
        if (acc_sum[32] == acc_sum[31]) begin
            acc_sat = acc_sum[31:0];
        end else if (acc_sum[32]) begin
            acc_sat = 32'sh8000_0000;
        end else begin
            acc_sat = 32'sh7fff_ffff;
        end
        out_xfer = r_out_valid && !i_stall;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_ANG;
            S_ANG:   n_state = S_DT;
            S_DT:    n_state = S_DELTA;
            S_DELTA: n_state = S_HEAD;
            S_HEAD:  n_state = S_K;
            S_K:     n_state = S_EST;
            S_EST:   n_state = S_CORR;
            S_CORR:  n_state = S_ADJ;
            S_ADJ:   n_state = S_T;
            S_T:     n_state = S_U;
            S_U:     n_state = S_S;
            S_S:     n_state = S_TRIG;
            S_TRIG:  n_state = S_POS;
            S_POS:   n_state = S_ACC;
            S_ACC:   n_state = r_sin_pass ? S_DONE : S_K;
            S_DONE:  if (!r_out_valid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_ANG: begin
                mul_a = {{16{diff[16]}}, diff};
                mul_b = {17'b0, r_iwb};
            end
            S_DT: begin
                mul_a = {ang_sat[31], ang_sat};
                mul_b = {17'b0, r_dt};
            end
            S_DELTA: begin
                mul_a = {q_rad[31], q_rad};
                mul_b = {3'b0, INV_TWO_PI_Q32};
            end
            S_K: begin
                mul_a = {17'b0, head_sel};
                mul_b = DEPTH_OP;
            end
            S_EST: begin
                mul_a = MUL_W'({k_idx, 16'h0});
                mul_b = RECIP_OP;
            end
            S_CORR: begin
                mul_a = {17'b0, est};
                mul_b = DEPTH_OP;
            end
            S_ADJ: begin
                mul_a = {16'b0, z_val};
                mul_b = {16'b0, z_val};
            end
            S_T: begin
                mul_a = {16'b0, hi17};
                mul_b = {16'b0, POLY_C0};
            end
            S_U: begin
                mul_a = {16'b0, r_z2};
                mul_b = {16'b0, 17'(POLY_C1 - hi17)};
            end
            S_S: begin
                mul_a = {16'b0, r_z};
                mul_b = {16'b0, 17'(POLY_C2 - hi17)};
            end
            S_TRIG: begin
                mul_a = {{17{r_lin[15]}}, r_lin};
                mul_b = {{16{trig[16]}}, trig};
            end
            S_POS: begin
                mul_a = prod[32:0];
                mul_b = {17'b0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iwb       <= IWB_RESET;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_iwb <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_HEAD: r_head <= 16'(r_head + delta);
                S_ACC: begin
                    if (r_sin_pass) begin
                        r_y <= acc_sat;
                    end else begin
                        r_x <= acc_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_left  <= i_in.left_wheel_speed;
                r_right <= i_in.right_wheel_speed;
                r_dt    <= i_in.time_step;
            end
            S_ANG:  r_lin <= lin_sum[16:1];
            S_DT:   r_ang <= ang_sat;
            S_HEAD: r_sin_pass <= 1'b0;
            S_EST:  r_k <= k_idx;
            S_CORR: r_est <= est;
            S_ADJ: begin
                r_z    <= z_val;
                r_quad <= ang_a[15:14];
            end
            S_T:    r_z2 <= hi17;
            S_ACC:  r_sin_pass <= 1'b1;
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    r_out.position_x       <= r_x;
                    r_out.position_y       <= r_y;
                    r_out.heading_angle    <= r_head;
                    r_out.linear_velocity  <= r_lin;
                    r_out.angular_velocity <= r_ang;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
